// ===== src/kts_pkg.sv =====
`default_nettype none

package kts_pkg;

  localparam int NODE_W = 6;
  localparam int CFG_W  = 7;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_ARC     = 9'b000000010,
    S_CNT_RD  = 9'b000000100,
    S_CNT_ADD = 9'b000001000,
    S_SEED    = 9'b000010000,
    S_ENQ     = 9'b000100000,
    S_QWAIT   = 9'b001000000,
    S_VISIT   = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_t;

  typedef struct packed {
    logic clr;
    logic add;
    logic sub;
  } deg_ctl_t;

endpackage

`default_nettype wire

// ===== src/kahn_topological_sort.sv =====
`default_nettype none

// Kahn topological sort over up to MAX_NODES nodes. Arcs are loaded one per request; each arc
// is a read and then a write-back of its adjacency row. A request with last set starts the
// sort and the block stalls its input until the final result has been loaded into the output
// register. In-degree counting reads the adjacency rows one at a time, and each served node
// costs one queue write, one queue read, one adjacency row read and one visit step, all
// through the single read port of each memory; a visit that must emit the previous node, and
// the final result, wait while the output is stalled. In-degrees live in per-node counters
// updated a whole row at a time. The matrix is cleared at the end of the sort through per-row
// valid bits, so no clearing pass is needed after reset or between graphs.
module kahn_topological_sort #(
  parameter int MAX_NODES = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_wr_en,
  input  wire logic [kts_pkg::CFG_W-1:0]    cfg_wr_data,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [kts_pkg::NODE_W-1:0]   in_src_node,
  input  wire logic [kts_pkg::NODE_W-1:0]   in_dst_node,
  input  wire logic                         in_arc_valid,
  input  wire logic                         in_last,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [kts_pkg::NODE_W-1:0]   out_node,
  output logic                              out_node_valid,
  output logic                              out_final_res,
  output logic                              out_acyclic
);

  localparam int ROW_AW = $clog2(MAX_NODES);
  localparam int CNT_W  = $clog2(MAX_NODES + 1);

  kts_pkg::state_t state_r, state_nxt;

  logic [kts_pkg::CFG_W-1:0] node_count_r;
  logic [CNT_W-1:0]          n_eff;
  logic [MAX_NODES-1:0]      live;

  logic [CNT_W-1:0]     rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]     head_r, head_nxt;
  logic [CNT_W-1:0]     tail_r, tail_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [MAX_NODES-1:0] pend_r, pend_nxt;
  logic                 held_r, held_nxt;
  logic [ROW_AW-1:0]    held_node_r, held_node_nxt;
  logic [ROW_AW-1:0]    cur_r, cur_nxt;
  logic [MAX_NODES-1:0] arc_bit_r, arc_bit_nxt;
  logic [ROW_AW-1:0]    arc_row_r, arc_row_nxt;
  logic                 arc_last_r, arc_last_nxt;

  logic                        out_valid_r;
  logic [kts_pkg::NODE_W-1:0]  out_node_r;
  logic                        out_node_valid_r;
  logic                        out_final_res_r;
  logic                        out_acyclic_r;

  logic                       emit;
  logic [kts_pkg::NODE_W-1:0] e_node;
  logic                       e_nv;
  logic                       e_fin;
  logic                       e_acy;
  logic                       out_free;

  logic                 in_acc;
  logic                 arc_ok;
  logic [ROW_AW-1:0]    lo_idx;

  logic                 adj_rd_en;
  logic [ROW_AW-1:0]    adj_rd_addr;
  logic [MAX_NODES-1:0] adj_rd_data;
  logic                 adj_wr_en;
  logic [MAX_NODES-1:0] adj_wr_data;
  logic                 adj_clr;
  logic [MAX_NODES-1:0] row_m;

  logic                 q_wr_en;
  logic                 q_rd_en;
  logic [ROW_AW-1:0]    q_rd_data;

  kts_pkg::deg_ctl_t    deg_ctl;
  logic [MAX_NODES-1:0] zero_mask;
  logic [MAX_NODES-1:0] one_mask;

  assign n_eff = (node_count_r > kts_pkg::CFG_W'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                            : node_count_r[CNT_W-1:0];

  for (genvar j = 0; j < MAX_NODES; j++) begin : g_live
    assign live[j] = (CNT_W'(j) < n_eff);
  end

  assign in_stall = (state_r != kts_pkg::S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign arc_ok   = in_arc_valid
                 && (kts_pkg::CFG_W'(in_src_node) < kts_pkg::CFG_W'(n_eff))
                 && (kts_pkg::CFG_W'(in_dst_node) < kts_pkg::CFG_W'(n_eff));
  assign out_free = !out_valid_r || !out_stall;
  assign row_m    = adj_rd_data & live;

  always_comb begin
    lo_idx = '0;
    for (int k = MAX_NODES - 1; k >= 0; k--) begin
      if (pend_r[k]) begin
        lo_idx = ROW_AW'(k);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    rd_idx_nxt    = rd_idx_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = pend_r;
    held_nxt      = held_r;
    held_node_nxt = held_node_r;
    cur_nxt       = cur_r;
    arc_bit_nxt   = arc_bit_r;
    arc_row_nxt   = arc_row_r;
    arc_last_nxt  = arc_last_r;
    adj_rd_en     = 1'b0;
    adj_rd_addr   = '0;
    adj_wr_en     = 1'b0;
    adj_wr_data   = adj_rd_data | arc_bit_r;
    adj_clr       = 1'b0;
    q_wr_en       = 1'b0;
    q_rd_en       = 1'b0;
    deg_ctl       = '0;
    emit          = 1'b0;
    e_node        = '0;
    e_nv          = 1'b0;
    e_fin         = 1'b0;
    e_acy         = 1'b0;

    case (state_r)
      kts_pkg::S_IDLE: begin
        if (in_acc) begin
          if (arc_ok) begin
            adj_rd_en    = 1'b1;
            adj_rd_addr  = in_src_node[ROW_AW-1:0];
            arc_row_nxt  = in_src_node[ROW_AW-1:0];
            arc_bit_nxt  = MAX_NODES'(1) << in_dst_node[ROW_AW-1:0];
            arc_last_nxt = in_last;
            state_nxt    = kts_pkg::S_ARC;
          end else if (in_last) begin
            deg_ctl.clr = 1'b1;
            rd_idx_nxt  = '0;
            head_nxt    = '0;
            tail_nxt    = '0;
            cnt_nxt     = '0;
            held_nxt    = 1'b0;
            state_nxt   = kts_pkg::S_CNT_RD;
          end
        end
      end
      kts_pkg::S_ARC: begin
        adj_wr_en = 1'b1;
        if (arc_last_r) begin
          deg_ctl.clr = 1'b1;
          rd_idx_nxt  = '0;
          head_nxt    = '0;
          tail_nxt    = '0;
          cnt_nxt     = '0;
          held_nxt    = 1'b0;
          state_nxt   = kts_pkg::S_CNT_RD;
        end else begin
          state_nxt = kts_pkg::S_IDLE;
        end
      end
      kts_pkg::S_CNT_RD: begin
        if (rd_idx_r == n_eff) begin
          state_nxt = kts_pkg::S_SEED;
        end else begin
          adj_rd_en   = 1'b1;
          adj_rd_addr = rd_idx_r[ROW_AW-1:0];
          state_nxt   = kts_pkg::S_CNT_ADD;
        end
      end
      kts_pkg::S_CNT_ADD: begin
        deg_ctl.add = 1'b1;
        rd_idx_nxt  = rd_idx_r + CNT_W'(1);
        state_nxt   = kts_pkg::S_CNT_RD;
      end
      kts_pkg::S_SEED: begin
        pend_nxt  = live & zero_mask;
        state_nxt = kts_pkg::S_ENQ;
      end
      kts_pkg::S_ENQ: begin
        if (pend_r != '0) begin
          q_wr_en          = 1'b1;
          tail_nxt         = tail_r + CNT_W'(1);
          pend_nxt[lo_idx] = 1'b0;
        end else if (head_r != tail_r) begin
          q_rd_en   = 1'b1;
          state_nxt = kts_pkg::S_QWAIT;
        end else begin
          state_nxt = kts_pkg::S_DONE;
        end
      end
      kts_pkg::S_QWAIT: begin
        adj_rd_en   = 1'b1;
        adj_rd_addr = q_rd_data;
        cur_nxt     = q_rd_data;
        state_nxt   = kts_pkg::S_VISIT;
      end
      kts_pkg::S_VISIT: begin
        if (!held_r || out_free) begin
          if (held_r) begin
            emit   = 1'b1;
            e_node = kts_pkg::NODE_W'(held_node_r);
            e_nv   = 1'b1;
          end
          deg_ctl.sub   = 1'b1;
          pend_nxt      = row_m & one_mask;
          held_nxt      = 1'b1;
          held_node_nxt = cur_r;
          cnt_nxt       = cnt_r + CNT_W'(1);
          head_nxt      = head_r + CNT_W'(1);
          state_nxt     = kts_pkg::S_ENQ;
        end
      end
      kts_pkg::S_DONE: begin
        if (out_free) begin
          emit  = 1'b1;
          e_fin = 1'b1;
          if (held_r) begin
            e_node = kts_pkg::NODE_W'(held_node_r);
            e_nv   = 1'b1;
            e_acy  = (cnt_r == n_eff);
          end else begin
            e_acy = (n_eff == '0);
          end
          adj_clr   = 1'b1;
          held_nxt  = 1'b0;
          state_nxt = kts_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = kts_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= kts_pkg::S_IDLE;
      node_count_r <= '0;
      rd_idx_r     <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      cnt_r        <= '0;
      pend_r       <= '0;
      held_r       <= 1'b0;
      arc_last_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rd_idx_r   <= rd_idx_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      cnt_r      <= cnt_nxt;
      pend_r     <= pend_nxt;
      held_r     <= held_nxt;
      arc_last_r <= arc_last_nxt;
      if (cfg_wr_en) begin
        node_count_r <= cfg_wr_data;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    held_node_r <= held_node_nxt;
    cur_r       <= cur_nxt;
    arc_bit_r   <= arc_bit_nxt;
    arc_row_r   <= arc_row_nxt;
    if (emit) begin
      out_node_r       <= e_node;
      out_node_valid_r <= e_nv;
      out_final_res_r  <= e_fin;
      out_acyclic_r    <= e_acy;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_node       = out_node_r;
  assign out_node_valid = out_node_valid_r;
  assign out_final_res  = out_final_res_r;
  assign out_acyclic    = out_acyclic_r;

  kts_adj_mem #(
    .ROWS   (MAX_NODES),
    .ROW_AW (ROW_AW)
  ) u_adj (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (adj_rd_en),
    .rd_addr (adj_rd_addr),
    .rd_data (adj_rd_data),
    .wr_en   (adj_wr_en),
    .wr_addr (arc_row_r),
    .wr_data (adj_wr_data),
    .clr     (adj_clr)
  );

  kts_queue_mem #(
    .DEPTH  (MAX_NODES),
    .ADDR_W (ROW_AW)
  ) u_queue (
    .clk     (clk),
    .wr_en   (q_wr_en),
    .wr_addr (tail_r[ROW_AW-1:0]),
    .wr_data (lo_idx),
    .rd_en   (q_rd_en),
    .rd_addr (head_r[ROW_AW-1:0]),
    .rd_data (q_rd_data)
  );

  kts_deg_lanes #(
    .LANES (MAX_NODES),
    .CNT_W (CNT_W)
  ) u_deg (
    .clk       (clk),
    .ctl       (deg_ctl),
    .row       (row_m),
    .zero_mask (zero_mask),
    .one_mask  (one_mask)
  );

endmodule

`default_nettype wire

// ===== src/kts_adj_mem.sv =====
`default_nettype none

module kts_adj_mem #(
  parameter int ROWS   = 64,
  parameter int ROW_AW = 6
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              rd_en,
  input  wire logic [ROW_AW-1:0] rd_addr,
  output logic      [ROWS-1:0]   rd_data,
  input  wire logic              wr_en,
  input  wire logic [ROW_AW-1:0] wr_addr,
  input  wire logic [ROWS-1:0]   wr_data,
  input  wire logic              clr
);

  logic [ROWS-1:0] mem [ROWS];
  logic [ROWS-1:0] row_vld_r;
  logic [ROWS-1:0] rd_q_r;
  logic            rd_vld_r;

  // A row whose valid bit is clear reads as all zero, so the whole matrix
  // is cleared by clearing the valid bits.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r   <= mem[rd_addr];
      rd_vld_r <= row_vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (clr) begin
      row_vld_r <= '0;
    end else if (wr_en) begin
      row_vld_r[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

`default_nettype wire

// ===== src/kts_queue_mem.sv =====
`default_nettype none

module kts_queue_mem #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [ADDR_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [ADDR_W-1:0] rd_data
);

  logic [ADDR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== src/kts_deg_lanes.sv =====
`default_nettype none

module kts_deg_lanes #(
  parameter int LANES = 64,
  parameter int CNT_W = 7
) (
  input  wire logic             clk,
  input  wire kts_pkg::deg_ctl_t ctl,
  input  wire logic [LANES-1:0] row,
  output logic      [LANES-1:0] zero_mask,
  output logic      [LANES-1:0] one_mask
);

  for (genvar j = 0; j < LANES; j++) begin : g_lane
    logic [CNT_W-1:0] deg_r;

    always_ff @(posedge clk) begin
      if (ctl.clr) begin
        deg_r <= '0;
      end else if (ctl.add && row[j]) begin
        deg_r <= deg_r + CNT_W'(1);
      end else if (ctl.sub && row[j] && (deg_r != '0)) begin
        deg_r <= deg_r - CNT_W'(1);
      end
    end

    assign zero_mask[j] = (deg_r == '0);
    assign one_mask[j]  = (deg_r == CNT_W'(1));
  end

endmodule

`default_nettype wire

// ===== src/kts_checker.sv =====
`default_nettype none

module kts_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_stall,
  input wire logic                       in_last,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic [kts_pkg::NODE_W-1:0] out_node,
  input wire logic                       out_node_valid,
  input wire logic                       out_final_res,
  input wire logic                       out_acyclic
);

  // A request that ends a graph blocks the input while the sort runs.
  a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last) |=> in_stall)
    else $error("input not stalled after a last request");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_node)
      && $stable(out_node_valid) && $stable(out_final_res) && $stable(out_acyclic)))
    else $error("stalled result changed");

  a_mid_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_final_res) |-> (out_node_valid && !out_acyclic))
    else $error("non-final result without a node or with acyclic set");

  a_empty_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_node_valid) |-> (out_final_res && (out_node == '0)))
    else $error("result without a node is not the final one");

endmodule

bind kahn_topological_sort kts_checker u_kts_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_last        (in_last),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_node       (out_node),
  .out_node_valid (out_node_valid),
  .out_final_res  (out_final_res),
  .out_acyclic    (out_acyclic)
);

`default_nettype wire
